// ===== src/bmhq_pkg.sv =====
// Package: shared constants and types for the binary min-heap queue core.
package bmhq_pkg;

	localparam int unsigned CAPACITY_DEF = 512;

	typedef enum logic [2:0] {
		MODE_INSERT  = 3'd0,
		MODE_EXTRACT = 3'd1,
		MODE_UPDATE  = 3'd2,
		MODE_APPEND  = 3'd3,
		MODE_HEAPIFY = 3'd4,
		MODE_CLEAR   = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_NOTAG = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXT_RD,
		S_EXT_WR,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RDL,
		S_DN_RDR,
		S_DN_CMP,
		S_DN_SWP,
		S_HEAP_NXT,
		S_HEAP_LD,
		S_DONE
	} state_t;

endpackage

// ===== src/bmhq_ram.sv =====
// Generic single-port RAM with registered read data.
module bmhq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write or read one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== src/binary_min_heap_queue_core.sv =====
// Top level: binary min-heap priority queue over one entry RAM, run by a sequencer.
//
//  channel | signals                          | direction | handshake
//  command | start, mode, tag, weight         | in        | start & !busy
//  result  | done, status, out_tag,           | out       | done, one cycle,
//          | out_weight, occupancy            |           | no back-pressure
//
// Append, clear, heapify of fewer than two entries and every rejected command
// go straight to done; insert reads each parent and moves it down until the
// entry parks; extract reads the root, moves the last entry up to it and sinks
// that entry child by child; update searches the entries in order for the tag
// before its sift; heapify loads each inner node and sifts it down. Every step
// costs one access of the single RAM port. No clearing pass after reset: only
// entries below the count are read. busy is high from the accepted command
// through the done cycle; the receiver cannot stall.
module binary_min_heap_queue_core
	import bmhq_pkg::*;
#(
	parameter int unsigned CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [2:0]                        mode,
	input  logic [8:0]                        tag,
	input  logic [31:0]                       weight,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [8:0]                        out_tag,
	output logic [31:0]                       out_weight,
	output logic [9:0]                        occupancy
);
	import bmhq_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = AW + 1;
	localparam int unsigned EW = 41;

	state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [AW-1:0] pos_q, heap_q;
	logic [EW-1:0] cur_q, lft_q, ent_q;
	logic [2:0]    mode_q;
	logic [8:0]    tag_q;
	logic [1:0]    status_q;
	logic [8:0]    otag_q;
	logic [31:0]   ow_q;

	logic          we;
	logic [AW-1:0] addr;
	logic [EW-1:0] wdata, rdata;

	bmhq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	// child and parent indexes, widened so overflow past the array shows
	logic [AW:0]   left_w, par_w;
	logic [AW+1:0] right_w;
	assign left_w  = {pos_q, 1'b1};
	assign right_w = {1'b0, pos_q, 1'b0} + (AW+2)'(2);
	assign par_w   = ({1'b0, pos_q} - {{AW{1'b0}}, 1'b1}) >> 1;
	logic left_ok, right_ok;
	assign left_ok  = left_w < count_q;
	assign right_ok = right_w < {1'b0, count_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (mode)
						MODE_INSERT, MODE_APPEND:
							state_d = (count_q >= CW'(CAPACITY)) ? S_DONE :
								((mode == MODE_INSERT) ? S_UP_RD : S_DONE);
						MODE_EXTRACT: state_d = (count_q == '0) ? S_DONE : S_EXT_RD;
						MODE_UPDATE:  state_d = (count_q == '0) ? S_DONE : S_SRCH_RD;
						MODE_HEAPIFY: state_d = (count_q < CW'(2)) ? S_DONE : S_HEAP_NXT;
						default:      state_d = S_DONE;
					endcase
				end
			end
			S_EXT_RD:  state_d = S_EXT_WR;
			S_EXT_WR:  state_d = S_DN_RDL;
			S_SRCH_RD: state_d = S_SRCH_CMP;
			S_SRCH_CMP: begin
				if (rdata[40:32] == tag_q) begin
					state_d = (ent_q[31:0] < rdata[31:0]) ? S_UP_RD : S_DN_RDL;
				end else if ({1'b0, pos_q} + CW'(1) >= count_q) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SRCH_RD;
				end
			end
			S_UP_RD:  state_d = (pos_q == '0) ? S_DONE : S_UP_CMP;
			S_UP_CMP: state_d = (rdata[31:0] > cur_q[31:0]) ? S_UP_RD : S_DONE;
			S_DN_RDL: state_d = left_ok ? S_DN_RDR : S_HEAP_NXT;
			S_DN_RDR: state_d = S_DN_CMP;
			S_DN_CMP: begin
				if (right_ok && rdata[31:0] < cur_q[31:0] && !(lft_q[31:0] < cur_q[31:0]
					&& !(rdata[31:0] < lft_q[31:0]))) state_d = S_DN_SWP;
				else if (lft_q[31:0] < cur_q[31:0]) state_d = S_DN_SWP;
				else state_d = S_HEAP_NXT;
			end
			S_DN_SWP:   state_d = S_DN_RDL;
			S_HEAP_NXT: state_d = (mode_q == MODE_HEAPIFY && heap_q != '0) ? S_HEAP_LD : S_DONE;
			S_HEAP_LD:  state_d = S_DN_RDL;
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// right child wins only when strictly below both node and left child
	logic pick_right;
	assign pick_right = right_ok && rdata[31:0] < cur_q[31:0]
		&& rdata[31:0] < lft_q[31:0];

	// RAM port control
	always_comb begin
		we = 1'b0;
		addr = pos_q;
		wdata = cur_q;
		case (state_q)
			S_IDLE: begin
				addr = count_q[AW-1:0];
				wdata = {tag, weight};
				we = start && (mode == MODE_INSERT || mode == MODE_APPEND)
					&& count_q < CW'(CAPACITY);
				if (start && mode == MODE_EXTRACT) addr = '0;
			end
			S_EXT_RD: addr = count_q[AW-1:0];
			S_EXT_WR: begin
				we = 1'b1; addr = '0; wdata = rdata;
			end
			S_SRCH_RD: addr = pos_q;
			S_SRCH_CMP: begin
				addr = pos_q;
				wdata = {rdata[40:32], ent_q[31:0]};
				we = rdata[40:32] == tag_q;
			end
			// park the climbing entry once it reaches the root
			S_UP_RD: begin
				if (pos_q == '0) begin
					we = 1'b1; addr = pos_q; wdata = cur_q;
				end else begin
					addr = par_w[AW-1:0];
				end
			end
			// move the parent down, or park the climbing entry here
			S_UP_CMP: begin
				addr = pos_q; we = 1'b1;
				wdata = (rdata[31:0] > cur_q[31:0]) ? rdata : cur_q;
			end
			S_DN_RDL: addr = left_w[AW-1:0];
			S_DN_RDR: addr = right_w[AW-1:0];
			S_DN_CMP: begin
				if (pick_right) begin
					we = 1'b1; addr = pos_q; wdata = rdata;
				end else if (lft_q[31:0] < cur_q[31:0]) begin
					we = 1'b1; addr = pos_q; wdata = lft_q;
				end
			end
			S_DN_SWP: begin
				we = 1'b1; addr = pos_q; wdata = cur_q;
			end
			S_HEAP_NXT: addr = heap_q - AW'(1);
			default: ;
		endcase
	end

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			mode_q   <= '0;
			tag_q    <= '0;
			ent_q    <= '0;
			cur_q    <= '0;
			lft_q    <= '0;
			pos_q    <= '0;
			heap_q   <= '0;
			otag_q   <= '0;
			ow_q     <= '0;
			status_q <= ST_OK;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q <= mode;
						tag_q <= tag;
						ent_q <= {tag, weight};
						cur_q <= {tag, weight};
						status_q <= ST_OK;
						otag_q <= '0;
						ow_q <= '0;
						pos_q <= '0;
						case (mode)
							MODE_INSERT, MODE_APPEND: begin
								if (count_q >= CW'(CAPACITY)) status_q <= ST_FULL;
								else begin
									count_q <= count_q + CW'(1);
									pos_q <= count_q[AW-1:0];
								end
							end
							MODE_EXTRACT: begin
								if (count_q == '0) status_q <= ST_EMPTY;
								else count_q <= count_q - CW'(1);
							end
							MODE_UPDATE: status_q <= ST_NOTAG;
							MODE_HEAPIFY: heap_q <= AW'(count_q >> 1);
							MODE_CLEAR: count_q <= '0;
							default: ;
						endcase
					end
				end
				S_EXT_RD: begin
					otag_q <= rdata[40:32];
					ow_q <= rdata[31:0];
				end
				S_EXT_WR: cur_q <= rdata;
				S_SRCH_CMP: begin
					if (rdata[40:32] == tag_q) begin
						status_q <= ST_OK;
						cur_q <= {rdata[40:32], ent_q[31:0]};
					end else begin
						pos_q <= pos_q + AW'(1);
					end
				end
				S_UP_CMP: if (rdata[31:0] > cur_q[31:0]) pos_q <= par_w[AW-1:0];
				S_DN_RDR: lft_q <= rdata;
				S_DN_CMP: begin
					if (pick_right) pos_q <= right_w[AW-1:0];
					else if (lft_q[31:0] < cur_q[31:0]) pos_q <= left_w[AW-1:0];
				end
				// step to the next inner node; its entry is loaded in S_HEAP_LD
				S_HEAP_NXT: begin
					if (mode_q == MODE_HEAPIFY && heap_q != '0) begin
						heap_q <= heap_q - AW'(1);
						pos_q <= heap_q - AW'(1);
					end
				end
				S_HEAP_LD: cur_q <= rdata;
				default: ;
			endcase
		end
	end

	// outputs
	always_comb begin
		busy = state_q != S_IDLE;
		done = state_q == S_DONE;
		status = status_q;
		out_tag = otag_q;
		out_weight = ow_q;
		occupancy = 10'(count_q);
	end

	// assertions
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(CAPACITY))
		else $error("occupancy above capacity");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("done outside busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !(mode_q == MODE_EXTRACT && status_q == ST_OK))
		|-> (out_tag == '0 && out_weight == '0))
		else $error("entry returned outside a successful extract");
endmodule

// ===== bench/testbench.sv =====
// Testbench for the binary min-heap queue core: self-checking against a behavioral heap.
`timescale 1ns / 100ps

module testbench;
	import bmhq_pkg::*;

	localparam int HEAP_SIZE = 512;
	localparam int WATCHDOG_LIMIT = 200000;

	typedef struct packed {
		logic [2:0]  mode;
		logic [8:0]  tag;
		logic [31:0] weight;
		logic        wait_drain;
	} command_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [8:0]  out_tag;
		logic [31:0] out_weight;
		logic [9:0]  occupancy;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  mode;
	logic [8:0]  tag;
	logic [31:0] weight;
	logic        done;
	logic [1:0]  status;
	logic [8:0]  out_tag;
	logic [31:0] out_weight;
	logic [9:0]  occupancy;

	command_t command_queue[$];
	outcome_t expected_outcomes[$];

	// behavioral heap state
	logic [8:0]  heap_tags[HEAP_SIZE];
	logic [31:0] heap_weights[HEAP_SIZE];
	int          heap_count;

	int  send_idle_pct;
	int  error_count;
	int  commands_sent;
	int  outcomes_seen;
	int  extracts_seen;
	int  idle_cycles;
	bit  stimulus_done;
	bit  in_flight;

	binary_min_heap_queue_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.tag        (tag),
		.weight     (weight),
		.done       (done),
		.status     (status),
		.out_tag    (out_tag),
		.out_weight (out_weight),
		.occupancy  (occupancy)
	);

	always #4 clk = ~clk;

	function automatic void swap_entries(int a, int b);
		logic [8:0]  t;
		logic [31:0] w;
		t = heap_tags[a];
		w = heap_weights[a];
		heap_tags[a] = heap_tags[b];
		heap_weights[a] = heap_weights[b];
		heap_tags[b] = t;
		heap_weights[b] = w;
	endfunction

	function automatic void sink_entry(int pos);
		int best;
		while (pos < heap_count) begin
			best = pos;
			if (2 * pos + 1 < heap_count && heap_weights[2 * pos + 1] < heap_weights[best])
				best = 2 * pos + 1;
			if (2 * pos + 2 < heap_count && heap_weights[2 * pos + 2] < heap_weights[best])
				best = 2 * pos + 2;
			if (best == pos)
				break;
			swap_entries(pos, best);
			pos = best;
		end
	endfunction

	function automatic void raise_entry(int pos);
		int up;
		while (pos > 0) begin
			up = (pos - 1) / 2;
			if (heap_weights[up] > heap_weights[pos]) begin
				swap_entries(pos, up);
				pos = up;
			end else
				break;
		end
	endfunction

	// compute the outcome of one command and advance the heap
	function automatic outcome_t apply_heap_command(command_t c);
		outcome_t o;
		logic [31:0] old;
		o = '0;
		o.status = ST_OK;
		case (c.mode)
			MODE_INSERT, MODE_APPEND: begin
				if (heap_count >= HEAP_SIZE)
					o.status = ST_FULL;
				else begin
					heap_tags[heap_count] = c.tag;
					heap_weights[heap_count] = c.weight;
					heap_count++;
					if (c.mode == MODE_INSERT)
						raise_entry(heap_count - 1);
				end
			end
			MODE_EXTRACT: begin
				if (heap_count == 0)
					o.status = ST_EMPTY;
				else begin
					o.out_tag = heap_tags[0];
					o.out_weight = heap_weights[0];
					heap_count--;
					heap_tags[0] = heap_tags[heap_count];
					heap_weights[0] = heap_weights[heap_count];
					sink_entry(0);
				end
			end
			MODE_UPDATE: begin
				o.status = ST_NOTAG;
				for (int i = 0; i < heap_count; i++) begin
					if (heap_tags[i] == c.tag) begin
						old = heap_weights[i];
						heap_weights[i] = c.weight;
						if (c.weight < old)
							raise_entry(i);
						else
							sink_entry(i);
						o.status = ST_OK;
						break;
					end
				end
			end
			MODE_HEAPIFY: begin
				for (int i = heap_count / 2; i > 0; i--)
					sink_entry(i - 1);
			end
			MODE_CLEAR: heap_count = 0;
			default: ;
		endcase
		o.occupancy = heap_count[9:0];
		return o;
	endfunction

	function automatic logic [31:0] random_weight();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [8:0] random_tag();
		if ($urandom_range(0, 3) == 0)
			return 9'($urandom_range(0, 511));
		return 9'($urandom_range(0, 31));
	endfunction

	task automatic push_command(logic [2:0] m, logic [8:0] t, logic [31:0] w);
		command_t c;
		c.mode = m;
		c.tag = t;
		c.weight = w;
		c.wait_drain = 1'b0;
		command_queue.push_back(c);
	endtask

	task automatic push_pause();
		command_t c;
		c = '0;
		c.wait_drain = 1'b1;
		command_queue.push_back(c);
	endtask

	task automatic push_random_burst(int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				push_command(MODE_INSERT, random_tag(), random_weight());
			else if (pick < 65)
				push_command(MODE_EXTRACT, random_tag(), random_weight());
			else if (pick < 78)
				push_command(MODE_UPDATE, random_tag(), random_weight());
			else if (pick < 88)
				push_command(MODE_APPEND, random_tag(), random_weight());
			else if (pick < 93)
				push_command(MODE_HEAPIFY, random_tag(), random_weight());
			else if (pick < 95)
				push_command(MODE_CLEAR, random_tag(), random_weight());
			else
				push_command(3'($urandom_range(6, 7)), random_tag(), random_weight());
		end
	endtask

	// reset and stimulus
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_INSERT;
		tag = '0;
		weight = '0;
		heap_count = 0;
		error_count = 0;
		commands_sent = 0;
		outcomes_seen = 0;
		extracts_seen = 0;
		idle_cycles = 0;
		stimulus_done = 1'b0;
		in_flight = 1'b0;

		// directed: empty cases, extremes, ties, every mode
		push_command(MODE_EXTRACT, 9'd0, 32'd0);
		push_command(MODE_UPDATE, 9'd5, 32'd1);
		push_command(MODE_HEAPIFY, 9'd0, 32'd0);
		push_command(MODE_CLEAR, 9'd0, 32'd0);
		push_command(MODE_INSERT, 9'h1FF, 32'hFFFF_FFFF);
		push_command(MODE_INSERT, 9'd0, 32'd0);
		push_command(MODE_INSERT, 9'd7, 32'd5);
		push_command(MODE_INSERT, 9'd8, 32'd5);
		push_command(MODE_INSERT, 9'd7, 32'd3);
		push_command(MODE_UPDATE, 9'd7, 32'd5);
		push_command(MODE_UPDATE, 9'd7, 32'd1);
		push_command(MODE_UPDATE, 9'd8, 32'd5);
		push_command(MODE_UPDATE, 9'd99, 32'd1);
		push_command(MODE_APPEND, 9'h155, 32'hAAAA_AAAA);
		push_command(MODE_APPEND, 9'h0AA, 32'h5555_5555);
		push_command(MODE_APPEND, 9'd3, 32'd0);
		push_command(3'd6, 9'd1, 32'd1);
		push_command(3'd7, 9'd1, 32'd1);
		push_command(MODE_HEAPIFY, 9'd0, 32'd0);
		push_command(MODE_EXTRACT, 9'd0, 32'd0);
		push_command(MODE_EXTRACT, 9'd0, 32'd0);
		push_command(MODE_CLEAR, 9'd0, 32'd0);
		push_pause();

		// fill to capacity, hit full, then extract 40 entries and clear
		for (int i = 0; i < HEAP_SIZE; i++)
			push_command(i % 3 ? MODE_INSERT : MODE_APPEND, i[8:0], $urandom);
		push_command(MODE_INSERT, 9'd1, 32'd1);
		push_command(MODE_APPEND, 9'd1, 32'd1);
		push_command(MODE_HEAPIFY, 9'd0, 32'd0);
		push_command(MODE_UPDATE, 9'h1FF, 32'd0);
		for (int i = 0; i < 40; i++)
			push_command(MODE_EXTRACT, 9'd0, 32'd0);
		push_command(MODE_CLEAR, 9'd0, 32'd0);
		push_pause();

		// random phases with different sender idling
		push_random_burst(250);
		push_pause();
		push_random_burst(250);
		push_pause();
		push_random_burst(250);
		push_pause();
		push_random_burst(200);

		wait (arst_n);
		wait (command_queue.size() == 0 && !in_flight);
		stimulus_done = 1'b1;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// select the sender idling per phase from how far the stimulus has progressed
	always_comb begin
		if (commands_sent < 600)
			send_idle_pct = 0;
		else if (commands_sent < 850)
			send_idle_pct = 67;
		else if (commands_sent < 1100)
			send_idle_pct = 21;
		else if (commands_sent < 1350)
			send_idle_pct = 0;
		else
			send_idle_pct = 67;
	end

	// driver: issue one command per transfer, hold start until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			in_flight <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_outcomes.push_back(apply_heap_command({mode, tag, weight, 1'b0}));
				commands_sent <= commands_sent + 1;
			end
			if (!(start && busy)) begin
				if (command_queue.size() > 0 && command_queue[0].wait_drain) begin
					start <= 1'b0;
					if (expected_outcomes.size() == 0 && !(start && !busy) && !busy)
						void'(command_queue.pop_front());
				end else if (command_queue.size() > 0
						&& $urandom_range(0, 99) >= send_idle_pct) begin
					start <= 1'b1;
					mode <= command_queue[0].mode;
					tag <= command_queue[0].tag;
					weight <= command_queue[0].weight;
					void'(command_queue.pop_front());
				end else
					start <= 1'b0;
			end
			in_flight <= (command_queue.size() > 0) || (start && busy);
		end
	end

	// monitor: compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		outcome_t exp_o;
		if (arst_n && done) begin
			outcomes_seen <= outcomes_seen + 1;
			if (expected_outcomes.size() == 0) begin
				$display("%t: unexpected result status=%0d tag=%0d weight=%0d occ=%0d",
					$time, status, out_tag, out_weight, occupancy);
				error_count <= error_count + 1;
			end else begin
				exp_o = expected_outcomes.pop_front();
				if (exp_o.out_weight != 32'd0 || exp_o.out_tag != 9'd0)
					extracts_seen <= extracts_seen + 1;
				if (status !== exp_o.status) begin
					$display("%t: status expected %0d actual %0d", $time, exp_o.status, status);
					error_count <= error_count + 1;
				end
				if (out_tag !== exp_o.out_tag) begin
					$display("%t: out_tag expected %0d actual %0d", $time, exp_o.out_tag,
						out_tag);
					error_count <= error_count + 1;
				end
				if (out_weight !== exp_o.out_weight) begin
					$display("%t: out_weight expected %0d actual %0d", $time,
						exp_o.out_weight, out_weight);
					error_count <= error_count + 1;
				end
				if (occupancy !== exp_o.occupancy) begin
					$display("%t: occupancy expected %0d actual %0d", $time,
						exp_o.occupancy, occupancy);
					error_count <= error_count + 1;
				end
			end
		end
	end

	// watchdog: count cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// end of run: wait until the block is idle with nothing pending, then report
	initial begin
		wait (stimulus_done);
		do
			@(posedge clk);
		while (command_queue.size() != 0 || start || busy
			|| expected_outcomes.size() != 0);
		repeat (20) @(posedge clk);
		$display("Covered %0d commands and %0d results, %0d with a returned entry.",
			commands_sent, outcomes_seen, extracts_seen);
		if (error_count == 0 && expected_outcomes.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
